>>> design/bpa_pkg.sv
// bitmap page allocator package: map geometry, widths and memory word helpers
// no dependencies
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int MaxPages   = 4096;
    localparam int WordBits   = 64;
    localparam int WordCount  = MaxPages / WordBits;
    localparam int AddrW      = $clog2(WordCount);
    localparam int BitW       = $clog2(WordBits);
    localparam int PageW      = $clog2(MaxPages);
    localparam int CountW     = PageW + 1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef logic [WordBits-1:0] word_t;
    typedef logic [AddrW-1:0]    waddr_t;
    typedef logic [PageW-1:0]    page_t;
    typedef logic [CountW-1:0]   count_t;

    // memory request from the controller
    typedef struct packed {
        logic   rd_en;
        waddr_t rd_addr;
        logic   wr_en;
        waddr_t wr_addr;
        word_t  wr_data;
    } mem_req_t;

endpackage

>>> design/bpa_map_ram.sv
// page used map storage: one 64-bit word per address, registered read data
// uses bpa_pkg; reset state comes from an init sweep driven by the controller
`timescale 1ns / 1ps

module bpa_map_ram
    import bpa_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    output word_t    rd_data
);

    word_t mem [WordCount];
    word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/bpa_ctrl.sv
// allocator sequencer: init sweep, first-fit scan, mark and free passes
// uses bpa_pkg; drives bpa_map_ram through a mem_req_t
`timescale 1ns / 1ps

module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  logic     cmd_kind,
    input  page_t    cmd_start,
    input  count_t   cmd_count,
    input  count_t   limit_cfg,
    output logic     res_valid,
    input  logic     res_ready,
    output logic     res_success,
    output page_t    res_page,
    output mem_req_t req,
    input  word_t    rd_data
);

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_SCAN, ST_BITS, ST_MREAD, ST_MWAIT, ST_MOD, ST_DONE
    } state_t;

    state_t   state_reg;
    waddr_t   addr_reg;
    count_t   limit_reg;
    logic     mark_reg;
    count_t   cnt_reg;
    count_t   run_reg;
    count_t   pos_reg;
    count_t   cur_reg;
    count_t   end_reg;
    word_t    word_reg;
    logic     ok_reg;
    page_t    page_reg;

    // page index helpers
    logic [CountW:0] run_end;
    logic            word_in_range;
    logic            bit_used;
    logic [BitW-1:0] bsel;
    word_t           mod_mask;
    count_t          wbase;
    count_t          wtop;
    word_t           cur_word;
    count_t          run_start;

    assign run_end       = {1'b0, cur_reg} + {1'b0, cnt_reg};
    assign wbase         = {1'b0, addr_reg, {BitW{1'b0}}};
    assign wtop          = wbase + count_t'(WordBits);
    assign bsel          = pos_reg[BitW-1:0];
    // first page of a word comes straight from the memory output
    assign cur_word      = (pos_reg == wbase) ? rd_data : word_reg;
    assign bit_used      = cur_word[bsel];
    assign word_in_range = wbase < limit_reg;
    assign run_start     = pos_reg + 1'b1 - cnt_reg;

    always_comb begin
        mod_mask = '0;
        for (int i = 0; i < WordBits; i++) begin
            if ((wbase + count_t'(i)) >= cur_reg && (wbase + count_t'(i)) < end_reg) begin
                mod_mask[i] = 1'b1;
            end
        end
    end

    always_comb begin
        req         = '0;
        req.rd_addr = addr_reg;
        req.wr_addr = addr_reg;
        case (state_reg)
            ST_INIT: begin
                req.wr_en   = 1'b1;
                req.wr_data = '1;
            end
            ST_SCAN, ST_MREAD: begin
                req.rd_en = 1'b1;
            end
            ST_MOD: begin
                req.wr_en   = 1'b1;
                req.wr_data = mark_reg ? (word_reg | mod_mask) : (word_reg & ~mod_mask);
            end
            default: begin
            end
        endcase
    end

    assign cmd_ready   = (state_reg == ST_IDLE);
    assign res_valid   = (state_reg == ST_DONE);
    assign res_success = ok_reg;
    assign res_page    = page_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            addr_reg      <= '0;
        end else begin
            case (state_reg)
                ST_INIT: begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == waddr_t'(WordCount - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (cmd_valid) begin
                        limit_reg <= (limit_cfg > count_t'(MaxPages)) ?
                                     count_t'(MaxPages) : limit_cfg;
                        cnt_reg   <= cmd_count;
                        run_reg   <= '0;
                        pos_reg   <= '0;
                        page_reg  <= '0;
                        if (cmd_kind == KIND_FREE) begin
                            mark_reg  <= 1'b0;
                            cur_reg   <= {1'b0, cmd_start};
                            ok_reg    <= 1'b1;
                            state_reg <= ST_MREAD;
                            addr_reg  <= cmd_start[PageW-1:BitW];
                            end_reg   <= '0;
                        end else begin
                            mark_reg <= 1'b1;
                            ok_reg   <= 1'b0;
                            addr_reg <= '0;
                            if (cmd_count == '0 ||
                                cmd_count > ((limit_cfg > count_t'(MaxPages)) ?
                                             count_t'(MaxPages) : limit_cfg)) begin
                                state_reg <= ST_DONE;
                            end else begin
                                state_reg <= ST_SCAN;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (!word_in_range) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_BITS;
                    end
                end
                ST_BITS: begin
                    // one page a cycle; a fully used word is skipped at once
                    if (pos_reg >= limit_reg) begin
                        state_reg <= ST_DONE;
                    end else if (pos_reg == wbase && rd_data == '1) begin
                        run_reg   <= '0;
                        pos_reg   <= wtop;
                        addr_reg  <= addr_reg + 1'b1;
                        state_reg <= (addr_reg == waddr_t'(WordCount - 1)) ?
                                     ST_DONE : ST_SCAN;
                    end else if (bit_used) begin
                        run_reg <= '0;
                        pos_reg <= pos_reg + 1'b1;
                        if (bsel == {BitW{1'b1}}) begin
                            addr_reg  <= addr_reg + 1'b1;
                            state_reg <= (addr_reg == waddr_t'(WordCount - 1)) ?
                                         ST_DONE : ST_SCAN;
                        end
                    end else if (run_reg + 1'b1 == cnt_reg) begin
                        cur_reg   <= run_start;
                        end_reg   <= pos_reg + 1'b1;
                        addr_reg  <= run_start[PageW-1:BitW];
                        page_reg  <= run_start[PageW-1:0];
                        ok_reg    <= 1'b1;
                        state_reg <= ST_MREAD;
                    end else begin
                        run_reg <= run_reg + 1'b1;
                        pos_reg <= pos_reg + 1'b1;
                        if (bsel == {BitW{1'b1}}) begin
                            addr_reg  <= addr_reg + 1'b1;
                            state_reg <= (addr_reg == waddr_t'(WordCount - 1)) ?
                                         ST_DONE : ST_SCAN;
                        end
                    end
                end
                ST_MREAD: begin
                    if (!mark_reg && end_reg == '0) begin
                        end_reg <= (run_end > {1'b0, limit_reg}) ?
                                   limit_reg : run_end[CountW-1:0];
                        if (cur_reg >= limit_reg || cnt_reg == '0) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_MWAIT;
                        end
                    end else if (cur_reg >= end_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_MWAIT;
                    end
                end
                ST_MWAIT: begin
                    state_reg <= ST_MOD;
                end
                ST_MOD: begin
                    addr_reg <= addr_reg + 1'b1;
                    if (wtop >= end_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_MREAD;
                    end
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // word register takes rd_data at a word's first page and in ST_MWAIT
    always_ff @(posedge aclk) begin
        if (state_reg == ST_BITS && pos_reg == wbase) begin
            word_reg <= rd_data;
        end else if (state_reg == ST_MWAIT) begin
            word_reg <= rd_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res_page))
        else $error("result dropped under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_ready |-> !res_valid)
        else $error("accepting while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        req.wr_en && req.rd_en |-> 1'b0)
        else $error("read and write overlap");

endmodule

>>> design/bitmap_page_allocator.sv
// bitmap first-fit page allocator top level
// uses bpa_pkg, bpa_ctrl and bpa_map_ram
//
// s_axis beat: allocate (tuser 0) or free (tuser 1) a run of pages.
// m_axis beat: one per input beat; tdata holds success and first page.
// cfg_we/cfg_wdata set the page limit (reset 4096); write them only
// while idle, which the block itself does not enforce. after reset the
// map is swept to all used, one write per map word; no beat is taken
// during the sweep. allocate: each 64-bit map word is read; a fully
// used word is skipped at once, a word with free pages is scanned one
// page per cycle; marking rewrites each touched word with a read, a
// wait and a write. free: the same read, wait and write per touched
// word, up to the page limit. one item is handled at a time; the
// result is held while m_axis_tready is low and the next beat is taken
// once it has been delivered.
`timescale 1ns / 1ps

module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // start_page[11:0], page_count[24:12]
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // success[0], first_page[12:1]
);

    count_t   limit_reg;
    mem_req_t req;
    word_t    rd_data;
    logic     success;
    page_t    first_page;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= count_t'(MaxPages);
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    bpa_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (s_axis_tvalid),
        .cmd_ready   (s_axis_tready),
        .cmd_kind    (s_axis_tuser),
        .cmd_start   (s_axis_tdata[11:0]),
        .cmd_count   (s_axis_tdata[24:12]),
        .limit_cfg   (limit_reg),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_success (success),
        .res_page    (first_page),
        .req         (req),
        .rd_data     (rd_data)
    );

    bpa_map_ram u_ram (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign m_axis_tdata = {3'b000, first_page, success};

endmodule

>>> dv/tb_bitmap_page_allocator.sv
// testbench for bitmap_page_allocator: first-fit allocate and free checked
// against a behavioral copy of the page map; depends on bpa_pkg and the rtl
`timescale 1ns / 1ps

module tb_bitmap_page_allocator
    import bpa_pkg::*;
();

    typedef struct packed {
        logic   kind;
        page_t  start_page;
        count_t page_count;
    } page_req_t;

    typedef struct packed {
        logic  success;
        page_t first_page;
    } page_resp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [12:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    bitmap_page_allocator u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    page_req_t   pending_reqs[$];
    page_resp_t  expected_resps[$];
    logic [MaxPages-1:0] used_map = '1;
    int          page_limit_reg = 4096;
    int          fail_count = 0;
    bit          hold_send = 1'b0;
    bit          quiet = 1'b0;

    function automatic page_resp_t predict_page_op(page_req_t r);
        page_resp_t o;
        int lim;
        int run;
        int s;
        o = '0;
        lim = (page_limit_reg > MaxPages) ? MaxPages : page_limit_reg;
        if (r.kind == KIND_FREE) begin
            for (int i = 0; i < r.page_count; i++) begin
                if (r.start_page + i >= lim) break;
                used_map[r.start_page + i] = 1'b0;
            end
            o.success = 1'b1;
            return o;
        end
        if (r.page_count == 0 || r.page_count > lim) return o;
        run = 0;
        for (int i = 0; i < lim; i++) begin
            if (used_map[i]) begin
                run = 0;
            end else begin
                run++;
                if (run == r.page_count) begin
                    s = i + 1 - r.page_count;
                    for (int k = s; k <= i; k++) used_map[k] = 1'b1;
                    o.success = 1'b1;
                    o.first_page = page_t'(s);
                    return o;
                end
            end
        end
        return o;
    endfunction

    // driver
    always @(posedge aclk) begin
        page_req_t r;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_resps.push_back(predict_page_op(pending_reqs.pop_front()));
            end
            if ((!s_axis_tvalid || s_axis_tready) || !aresetn) begin
                if (pending_reqs.size() > 0 && !hold_send &&
                    (quiet || $urandom_range(99) >= 27)) begin
                    r = pending_reqs[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= r.kind;
                    s_axis_tdata  <= {7'd0, r.page_count, r.start_page};
                end else if (s_axis_tvalid && s_axis_tready) begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        page_resp_t e;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_resps.size() == 0) begin
                    $error("unexpected result beat %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    e = expected_resps.pop_front();
                    if (m_axis_tdata[0] !== e.success) begin
                        $error("success: expected %0d actual %0d", e.success, m_axis_tdata[0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[12:1] !== e.first_page) begin
                        $error("first_page: expected %0d actual %0d",
                               e.first_page, m_axis_tdata[12:1]);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= quiet || ($urandom_range(99) >= 27);
        end
    end

    task automatic add_req(logic kind, int start_page, int page_count);
        page_req_t r;
        r.kind = kind;
        r.start_page = page_t'(start_page);
        r.page_count = count_t'(page_count);
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_resps.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic set_page_limit(int value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= 13'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        page_limit_reg = value;
        @(posedge aclk);
    endtask

    // mostly small runs, occasionally large ones
    task automatic add_random(int n, int lim);
        int c;
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(19) == 0) ? $urandom_range(8191) :
                ($urandom_range(3) == 0) ? $urandom_range(64) : $urandom_range(8);
            if ($urandom_range(2) == 0)
                add_req(KIND_FREE, ($urandom_range(3) == 0) ? $urandom_range(4095)
                                   : $urandom_range(lim > 0 ? lim : 1), c);
            else
                add_req(KIND_ALLOC, $urandom_range(4095), c);
        end
    endtask

    initial begin
        int limits[6];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        add_req(KIND_ALLOC, 0, 1);
        add_req(KIND_ALLOC, 0, 0);
        add_req(KIND_FREE, 0, 0);
        add_req(KIND_FREE, 4090, 100);
        add_req(KIND_FREE, 0, 4096);
        add_req(KIND_ALLOC, 4095, 4096);
        add_req(KIND_ALLOC, 0, 4097);
        add_req(KIND_ALLOC, 0, 8191);
        add_req(KIND_FREE, 100, 8191);
        add_req(KIND_FREE, 4095, 1);
        add_req(KIND_ALLOC, 0, 1);
        add_req(KIND_ALLOC, 0, 63);
        add_req(KIND_ALLOC, 0, 65);
        add_req(KIND_FREE, 10, 3);
        add_req(KIND_ALLOC, 0, 2);
        add_req(KIND_ALLOC, 0, 2);
        add_req(KIND_ALLOC, 0, 1);
        set_page_limit(100);
        add_req(KIND_FREE, 90, 50);
        add_req(KIND_ALLOC, 0, 101);
        add_req(KIND_ALLOC, 0, 4);
        set_page_limit(8191);
        add_req(KIND_ALLOC, 0, 4000);
        add_req(KIND_FREE, 0, 4096);

        // pause until the block is drained
        wait_drained();
        hold_send = 1'b1;
        repeat (20) @(posedge aclk);
        hold_send = 1'b0;

        limits = '{4096, 0, 1, 200, 8191, 4095};
        foreach (limits[j]) begin
            set_page_limit(limits[j]);
            quiet = (j == 3);
            add_random(300, limits[j] > 4096 ? 4096 : limits[j]);
        end
        wait_drained();
        quiet = 1'b0;
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #500ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
design/bpa_pkg.sv
design/bpa_map_ram.sv
design/bpa_ctrl.sv
design/bitmap_page_allocator.sv
dv/tb_bitmap_page_allocator.sv
